// ----- src/swas_pkg.sv -----
// Shared widths, limits and item kind codes of the sliding window anagram search.
package swas_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int ALPHABET    = 26;

    localparam int KIND_W   = 2;
    localparam int LETTER_W = 5;
    localparam int POS_W    = 32;

    // counts and lengths reach MAX_PATTERN itself
    localparam int COUNT_W = $clog2(MAX_PATTERN + 1);
    localparam int PTR_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [KIND_W-1:0] KIND_CLEAR   = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_PATTERN = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_TEXT    = KIND_W'(2);

    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [LETTER_W-1:0] t_letter;

endpackage

// ----- src/swas_if.sv -----
// Valid/ready channel interfaces for letter beats in and match beats out.
interface swas_in_if;
    import swas_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;

    modport source (output valid, output kind, output letter, input ready);
    modport sink   (input valid, input kind, input letter, output ready);
endinterface

interface swas_out_if;
    import swas_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] match_start;

    modport source (output valid, output match_start, input ready);
    modport sink   (input valid, input match_start, output ready);
endinterface

// ----- src/sliding_window_anagram_search_top.sv -----
// Sliding window anagram search: pattern histogram, letter ring, window histogram, match output.
//
// Takes one beat per clock cycle, sustained, as long as the match output is
// drained. A beat is first captured in an input register; once the output
// register can take a result, one pass of logic updates the window
// histogram for the new letter, compares all letter counts against the
// pattern histogram in parallel and drops the oldest letter from a full
// window, and a match position lands in the output register. That single
// histogram update-and-compare stage sets the rate.
// When the output register holds an untaken match, the input register still
// takes one more beat; only then does i_in.ready fall. Kind 0 clears the
// pattern, the window and the text position; kind 1 adds a pattern letter
// (letters past the pattern limit or outside the alphabet are ignored);
// kind 2 feeds a text letter, whose position counts from zero and wraps at
// 2^32. Matches never overlap: the window empties after each match. The
// letter ring needs no clearing pass, since only entries already written
// are ever read; the histograms and counters clear at reset at once.
module sliding_window_anagram_search_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    swas_in_if.sink          i_in,
    swas_out_if.source       o_out
);
    import swas_pkg::*;

    localparam int SUM_W = COUNT_W + 1;

    // input register
    logic             r_in_valid;
    logic [KIND_W-1:0] r_kind;
    t_letter          r_letter;

    // output register
    logic             r_out_valid;
    logic [POS_W-1:0] r_match_start;

    // search state
    t_count           r_pat_cnt [ALPHABET];
    t_count           r_win_cnt [ALPHABET];
    t_letter          r_ring    [MAX_PATTERN];
    t_count           r_pat_len;
    t_count           r_fill;
    logic [PTR_W-1:0] r_head;
    logic [POS_W-1:0] r_text_pos;

    t_count           n_pat_cnt [ALPHABET];
    t_count           n_win_cnt [ALPHABET];
    t_count           n_pat_len;
    t_count           n_fill;
    logic [PTR_W-1:0] n_head;
    logic [POS_W-1:0] n_text_pos;
    logic             n_hit;
    logic             n_ring_we;

    logic             proc_go;
    logic             letter_ok;
    logic             pat_room;
    logic             win_full;
    logic             hist_eq;
    logic [SUM_W-1:0] slot_sum;
    logic [PTR_W-1:0] slot;
    logic [PTR_W-1:0] head_inc;
    t_count           fill_inc;
    t_letter          old_letter;
    logic             old_ok;
    t_count           win_inc   [ALPHABET];
    t_count           win_dec   [ALPHABET];

    // advance the held beat whenever the output register is free or being taken
    assign proc_go    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc_go;

    assign o_out.valid       = r_out_valid;
    assign o_out.match_start = r_match_start;

    assign letter_ok = int'(r_letter) < ALPHABET;
    assign pat_room  = int'(r_pat_len) < MAX_PATTERN;
    assign fill_inc  = r_fill + COUNT_W'(1);
    assign win_full  = (fill_inc == r_pat_len);

    // ring slot of the new letter: head + fill stays below twice the ring size
    assign slot_sum = SUM_W'(r_head) + SUM_W'(r_fill);
    always_comb begin
        if (int'(slot_sum) >= MAX_PATTERN) begin
            slot = PTR_W'(slot_sum - SUM_W'(MAX_PATTERN));
        end else begin
            slot = PTR_W'(slot_sum);
        end
    end

    assign head_inc = (int'(r_head) == MAX_PATTERN - 1) ? '0 : r_head + PTR_W'(1);

    // an empty window means the oldest letter is the one entering right now
    assign old_letter = (r_fill == '0) ? r_letter : r_ring[r_head];
    assign old_ok     = int'(old_letter) < ALPHABET;

    // window histogram with the new letter, the compare, and the drop of the oldest
    always_comb begin
        hist_eq = 1'b1;
        for (int i = 0; i < ALPHABET; i++) begin
            win_inc[i] = r_win_cnt[i] + ((i == int'(r_letter)) ? COUNT_W'(1) : COUNT_W'(0));
            if (win_inc[i] != r_pat_cnt[i]) begin
                hist_eq = 1'b0;
            end
            if (old_ok && (i == int'(old_letter)) && (win_inc[i] != '0)) begin
                win_dec[i] = win_inc[i] - COUNT_W'(1);
            end else begin
                win_dec[i] = win_inc[i];
            end
        end
    end

    always_comb begin
        n_pat_cnt  = r_pat_cnt;
        n_win_cnt  = r_win_cnt;
        n_pat_len  = r_pat_len;
        n_fill     = r_fill;
        n_head     = r_head;
        n_text_pos = r_text_pos;
        n_hit      = 1'b0;
        n_ring_we  = 1'b0;
        if (proc_go) begin
            case (r_kind)
                KIND_CLEAR: begin
                    for (int i = 0; i < ALPHABET; i++) begin
                        n_pat_cnt[i] = '0;
                        n_win_cnt[i] = '0;
                    end
                    n_pat_len  = '0;
                    n_fill     = '0;
                    n_head     = '0;
                    n_text_pos = '0;
                end
                KIND_PATTERN: begin
                    if (letter_ok && pat_room) begin
                        for (int i = 0; i < ALPHABET; i++) begin
                            if (i == int'(r_letter)) begin
                                n_pat_cnt[i] = r_pat_cnt[i] + COUNT_W'(1);
                            end
                        end
                        n_pat_len = r_pat_len + COUNT_W'(1);
                    end
                end
                KIND_TEXT: begin
                    n_text_pos = r_text_pos + POS_W'(1);
                    if (r_pat_len == '0) begin
                        // no pattern: only the position moves
                    end else if (!letter_ok) begin
                        // a letter outside the alphabet breaks every window
                        for (int i = 0; i < ALPHABET; i++) begin
                            n_win_cnt[i] = '0;
                        end
                        n_fill = '0;
                        n_head = '0;
                    end else begin
                        n_ring_we = 1'b1;
                        if (win_full && hist_eq) begin
                            n_hit = 1'b1;
                            for (int i = 0; i < ALPHABET; i++) begin
                                n_win_cnt[i] = '0;
                            end
                            n_fill = '0;
                            n_head = '0;
                        end else if (win_full) begin
                            n_win_cnt = win_dec;
                            n_head    = head_inc;
                            n_fill    = r_fill;
                        end else begin
                            n_win_cnt = win_inc;
                            n_fill    = fill_inc;
                        end
                    end
                end
                default: begin
                    // unused kind: drop the beat
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ALPHABET; i++) begin
                r_pat_cnt[i] <= '0;
                r_win_cnt[i] <= '0;
            end
            r_pat_len  <= '0;
            r_fill     <= '0;
            r_head     <= '0;
            r_text_pos <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc_go) begin
                r_out_valid <= n_hit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_pat_cnt  <= n_pat_cnt;
            r_win_cnt  <= n_win_cnt;
            r_pat_len  <= n_pat_len;
            r_fill     <= n_fill;
            r_head     <= n_head;
            r_text_pos <= n_text_pos;
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind   <= i_in.kind;
            r_letter <= i_in.letter;
        end
        if (n_hit) begin
            // window start = current position - (pattern length - 1)
            r_match_start <= r_text_pos - POS_W'(r_pat_len) + POS_W'(1);
        end
        if (n_ring_we) begin
            r_ring[slot] <= r_letter;
        end
    end

endmodule

// ----- src/swas_checker.sv -----
// Port-level checks of the anagram search handshakes and result timing, bound to the top level.
module swas_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [swas_pkg::POS_W-1:0] i_match_start
);
    import swas_pkg::*;

    // hold a stalled match beat unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_match_start))
        else $error("match beat changed while stalled");

    // drop any result after reset
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("match valid after reset");

    // a new match follows an accepted beat through the input register and the output register
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("match without a beat two cycles before");

    // back-pressure on the input only comes from a stalled output
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while output free");

endmodule

bind sliding_window_anagram_search_top swas_checker u_swas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_match_start (o_out.match_start)
);
